[hw/rtl/mps_pkg.sv]
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types, defaults and helpers for the Markov appliance power sampler.
// ----------------------------------------------------------------------------
package mps_pkg;

  // Default configuration
  localparam int unsigned APPLIANCES_DEF    = 6;
  localparam int unsigned STATES_DEF        = 10;
  localparam int unsigned TIME_SLOTS_DEF    = 1024;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned POWER_W = 20;
  localparam int unsigned DRAW_W  = 16;

  // Request kind
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Load target
  typedef enum logic [1:0] {
    TBL_TRANS  = 2'd0,
    TBL_MEAN   = 2'd1,
    TBL_ONPROB = 2'd2,
    TBL_MAXPWR = 2'd3
  } tbl_sel_t;

  // One table write
  typedef struct packed {
    logic                 en;
    tbl_sel_t             sel;
    logic [2:0]           app;
    logic [3:0]           from_st;
    logic [3:0]           to_st;
    logic [9:0]           slot;
    logic [POWER_W-1:0]   value;
  } load_req_t;

  // Table read indices, data returns registered in the cycle after the request
  typedef struct packed {
    logic [2:0] app;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] mstate;
    logic [9:0] slot;
  } rd_req_t;

  // Rescale a Q0.16 draw to fb fraction bits (truncating)
  function automatic logic [31:0] scale_draw(input logic [DRAW_W-1:0] r,
                                             input int unsigned fb);
    logic [47:0] w;
    w = 48'(r) << fb;
    return 32'(w >> DRAW_W);
  endfunction

endpackage

[hw/rtl/mps_tables.sv]
// ----------------------------------------------------------------------------
// mps_tables
// Transition, mean fraction, on-probability and max power tables. One write
// port fed by load requests, one registered read per table each cycle.
// ----------------------------------------------------------------------------
module mps_tables #(
  parameter int unsigned APPLIANCES    = mps_pkg::APPLIANCES_DEF,
  parameter int unsigned STATES        = mps_pkg::STATES_DEF,
  parameter int unsigned TIME_SLOTS    = mps_pkg::TIME_SLOTS_DEF,
  parameter int unsigned FRACTION_BITS = mps_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  mps_pkg::load_req_t           load_req,
  input  mps_pkg::rd_req_t             rd_req,
  output logic [FRACTION_BITS:0]       trans_q,
  output logic [FRACTION_BITS:0]       mean_q,
  output logic [FRACTION_BITS:0]       onp_q,
  output logic [mps_pkg::POWER_W-1:0]  maxp_q
);

  localparam int unsigned PW    = FRACTION_BITS + 1;
  localparam int unsigned TR_D  = APPLIANCES * STATES * STATES;
  localparam int unsigned MF_D  = APPLIANCES * STATES;
  localparam int unsigned ON_D  = APPLIANCES * TIME_SLOTS;
  localparam int unsigned TR_AW = (TR_D > 1) ? $clog2(TR_D) : 1;
  localparam int unsigned MF_AW = (MF_D > 1) ? $clog2(MF_D) : 1;
  localparam int unsigned ON_AW = (ON_D > 1) ? $clog2(ON_D) : 1;
  localparam int unsigned AI_W  = (APPLIANCES > 1) ? $clog2(APPLIANCES) : 1;
  localparam logic [31:0] ONE_FIX = 32'(1) << FRACTION_BITS;

  logic [PW-1:0]               trans_mem_r [TR_D];
  logic [PW-1:0]               mean_mem_r  [MF_D];
  logic [PW-1:0]               onp_mem_r   [ON_D];
  logic [mps_pkg::POWER_W-1:0] maxp_mem_r  [APPLIANCES];

  logic [PW-1:0]               trans_q_r, mean_q_r, onp_q_r;
  logic [mps_pkg::POWER_W-1:0] maxp_q_r;

  logic [31:0]      val32;
  logic [PW-1:0]    sat_val;
  logic             ld_app_ok, ld_from_ok, ld_to_ok, ld_slot_ok;
  logic             tr_we, mf_we, on_we, mp_we;
  logic [TR_AW-1:0] tr_waddr, tr_raddr;
  logic [MF_AW-1:0] mf_waddr, mf_raddr;
  logic [ON_AW-1:0] on_waddr, on_raddr;
  logic [AI_W-1:0]  mp_widx, mp_ridx;
  logic             rd_app_ok, rd_slot_ok;
  logic [31:0]      rd_app32, rd_slot32;

  // Probability saturation to one
  assign val32   = 32'(load_req.value);
  assign sat_val = (val32 > ONE_FIX) ? ONE_FIX[PW-1:0] : val32[PW-1:0];

  // Load range checks and write decode
  assign ld_app_ok  = 32'(load_req.app) < APPLIANCES;
  assign ld_from_ok = 32'(load_req.from_st) < STATES;
  assign ld_to_ok   = 32'(load_req.to_st) < STATES;
  assign ld_slot_ok = 32'(load_req.slot) < TIME_SLOTS;

  always_comb begin
    tr_we = 1'b0;
    mf_we = 1'b0;
    on_we = 1'b0;
    mp_we = 1'b0;
    if (load_req.en && ld_app_ok) begin
      unique case (load_req.sel)
        mps_pkg::TBL_TRANS:  tr_we = ld_from_ok && ld_to_ok;
        mps_pkg::TBL_MEAN:   mf_we = ld_from_ok;
        mps_pkg::TBL_ONPROB: on_we = ld_slot_ok;
        mps_pkg::TBL_MAXPWR: mp_we = 1'b1;
        default:             mp_we = 1'b0;
      endcase
    end
  end

  assign tr_waddr = TR_AW'((32'(load_req.app) * STATES + 32'(load_req.from_st)) * STATES
                           + 32'(load_req.to_st));
  assign mf_waddr = MF_AW'(32'(load_req.app) * STATES + 32'(load_req.from_st));
  assign on_waddr = ON_AW'(32'(load_req.app) * TIME_SLOTS + 32'(load_req.slot));
  assign mp_widx  = AI_W'(load_req.app);

  // Read addresses, out-of-range appliance and slot indices folded to zero
  assign rd_app_ok  = 32'(rd_req.app) < APPLIANCES;
  assign rd_slot_ok = 32'(rd_req.slot) < TIME_SLOTS;
  assign rd_app32   = rd_app_ok ? 32'(rd_req.app) : 32'd0;
  assign rd_slot32  = rd_slot_ok ? 32'(rd_req.slot) : 32'd0;

  assign tr_raddr = TR_AW'((rd_app32 * STATES + 32'(rd_req.row)) * STATES
                           + 32'(rd_req.col));
  assign mf_raddr = MF_AW'(rd_app32 * STATES + 32'(rd_req.mstate));
  assign on_raddr = ON_AW'(rd_app32 * TIME_SLOTS + rd_slot32);
  assign mp_ridx  = AI_W'(rd_app32);

  // Memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (tr_we) begin
      trans_mem_r[tr_waddr] <= sat_val;
    end
    trans_q_r <= trans_mem_r[tr_raddr];
  end

  always_ff @(posedge clk) begin
    if (mf_we) begin
      mean_mem_r[mf_waddr] <= sat_val;
    end
    mean_q_r <= mean_mem_r[mf_raddr];
  end

  always_ff @(posedge clk) begin
    if (on_we) begin
      onp_mem_r[on_waddr] <= sat_val;
    end
    onp_q_r <= onp_mem_r[on_raddr];
  end

  always_ff @(posedge clk) begin
    if (mp_we) begin
      maxp_mem_r[mp_widx] <= load_req.value;
    end
    maxp_q_r <= maxp_mem_r[mp_ridx];
  end

  assign trans_q = trans_q_r;
  assign mean_q  = mean_q_r;
  assign onp_q   = onp_q_r;
  assign maxp_q  = maxp_q_r;

endmodule

[hw/rtl/markov_appliance_power_sampler_top.sv]
// ----------------------------------------------------------------------------
// markov_appliance_power_sampler_top
// Loads probability/power tables and steps one appliance Markov state per
// step request, returning on/off, new state and power.
// ----------------------------------------------------------------------------
// A load is written into its table when accepted. A step goes through the on
// check; when on, k = 1..STATES transition entries are scanned one per cycle
// by the shared add/compare unit, then the mean is read and scaled. in_stall
// is high until the result is handed to the output, plus any out_stall on a
// waiting result. Synchronous reset clears the sequencer, out_valid and every
// appliance state; tables are undefined until loaded.
module markov_appliance_power_sampler_top #(
  parameter int unsigned APPLIANCES    = mps_pkg::APPLIANCES_DEF,
  parameter int unsigned STATES        = mps_pkg::STATES_DEF,
  parameter int unsigned TIME_SLOTS    = mps_pkg::TIME_SLOTS_DEF,
  parameter int unsigned FRACTION_BITS = mps_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [1:0]                   in_table_select,
  input  logic [2:0]                   in_appliance,
  input  logic [3:0]                   in_from_state,
  input  logic [3:0]                   in_to_state,
  input  logic [9:0]                   in_time_slot,
  input  logic [mps_pkg::POWER_W-1:0]  in_load_value,
  input  logic [15:0]                  in_random_on,
  input  logic [15:0]                  in_random_state,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_appliance_out,
  output logic                         out_is_on,
  output logic [3:0]                   out_new_state,
  output logic [mps_pkg::POWER_W-1:0]  out_power
);

  localparam int unsigned PW     = FRACTION_BITS + 1;
  localparam int unsigned SUM_W  = FRACTION_BITS + 5;
  localparam int unsigned PROD_W = PW + mps_pkg::POWER_W;
  localparam int unsigned AI_W   = (APPLIANCES > 1) ? $clog2(APPLIANCES) : 1;
  localparam logic [3:0]  LAST_COL = 4'(STATES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONCHK,
    S_TRANS,
    S_MEAN,
    S_MUL,
    S_OUT
  } state_t;

  state_t                      state_r;
  logic [3:0]                  cur_state_r [APPLIANCES];
  logic [2:0]                  app_r;
  logic [3:0]                  st_r;
  logic [PW-1:0]               draw_on_r, draw_st_r;
  logic                        slot_ok_r;
  logic [3:0]                  col_r;
  logic [SUM_W-1:0]            sum_r;
  logic [3:0]                  new_st_r;
  logic                        is_on_r;
  logic [PROD_W-1:0]           prod_r;
  logic [mps_pkg::POWER_W-1:0] power_r;
  logic                        out_valid_r;
  logic [2:0]                  out_app_r;
  logic                        out_on_r;
  logic [3:0]                  out_st_r;
  logic [mps_pkg::POWER_W-1:0] out_power_r;

  mps_pkg::load_req_t          load_req;
  mps_pkg::rd_req_t            rd_req;
  logic [PW-1:0]               trans_q, mean_q, onp_q;
  logic [mps_pkg::POWER_W-1:0] maxp_q;

  logic                        in_acc;
  logic                        in_app_ok;
  logic                        on_hit;
  logic [SUM_W-1:0]            sum_nxt;
  logic                        col_hit;
  logic                        last_col;
  logic [PROD_W-1:0]           pwr_full;
  logic                        out_free;
  logic                        out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_app_ok = 32'(in_appliance) < APPLIANCES;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_OUT) && out_free;

  // Table write from load requests
  always_comb begin
    load_req.en      = in_acc && (in_kind == mps_pkg::KIND_LOAD);
    load_req.sel     = mps_pkg::tbl_sel_t'(in_table_select);
    load_req.app     = in_appliance;
    load_req.from_st = in_from_state;
    load_req.to_st   = in_to_state;
    load_req.slot    = in_time_slot;
    load_req.value   = in_load_value;
  end

  // Shared add/compare over the transition row
  assign sum_nxt  = sum_r + SUM_W'(trans_q);
  assign col_hit  = SUM_W'(draw_st_r) < sum_nxt;
  assign last_col = (col_r == LAST_COL);
  assign on_hit   = slot_ok_r && (draw_on_r < onp_q);

  // Table read indices for the next cycle
  always_comb begin
    rd_req.app    = (state_r == S_IDLE) ? in_appliance : app_r;
    rd_req.slot   = in_time_slot;
    rd_req.row    = st_r;
    rd_req.mstate = col_hit ? col_r : st_r;
    if (state_r == S_TRANS) begin
      rd_req.col = last_col ? col_r : col_r + 4'd1;
    end else begin
      rd_req.col = 4'd0;
    end
  end

  // Scaled power with saturation
  assign pwr_full = prod_r >> FRACTION_BITS;

  mps_tables #(
    .APPLIANCES    (APPLIANCES),
    .STATES        (STATES),
    .TIME_SLOTS    (TIME_SLOTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_tables (
    .clk      (clk),
    .load_req (load_req),
    .rd_req   (rd_req),
    .trans_q  (trans_q),
    .mean_q   (mean_q),
    .onp_q    (onp_q),
    .maxp_q   (maxp_q)
  );

  // Step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < int'(APPLIANCES); i++) begin
        cur_state_r[i] <= 4'd0;
      end
    end else begin
      // Result valid: set on hand-off, cleared once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_kind == mps_pkg::KIND_STEP) && in_app_ok) begin
            app_r     <= in_appliance;
            st_r      <= cur_state_r[AI_W'(in_appliance)];
            slot_ok_r <= 32'(in_time_slot) < TIME_SLOTS;
            draw_on_r <= PW'(mps_pkg::scale_draw(in_random_on, FRACTION_BITS));
            draw_st_r <= PW'(mps_pkg::scale_draw(in_random_state, FRACTION_BITS));
            state_r   <= S_ONCHK;
          end
        end
        S_ONCHK: begin
          is_on_r <= on_hit;
          if (on_hit) begin
            col_r   <= 4'd0;
            sum_r   <= '0;
            state_r <= S_TRANS;
          end else begin
            new_st_r <= st_r;
            power_r  <= '0;
            state_r  <= S_OUT;
          end
        end
        S_TRANS: begin
          if (col_hit || last_col) begin
            new_st_r <= col_hit ? col_r : st_r;
            cur_state_r[AI_W'(app_r)] <= col_hit ? col_r : st_r;
            state_r  <= S_MEAN;
          end else begin
            col_r <= col_r + 4'd1;
            sum_r <= sum_nxt;
          end
        end
        S_MEAN: begin
          prod_r  <= PROD_W'(mean_q) * PROD_W'(maxp_q);
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (|pwr_full[PROD_W-1:mps_pkg::POWER_W]) begin
            power_r <= '1;
          end else begin
            power_r <= pwr_full[mps_pkg::POWER_W-1:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_app_r   <= app_r;
            out_on_r    <= is_on_r;
            out_st_r    <= new_st_r;
            out_power_r <= power_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_appliance_out = out_app_r;
  assign out_is_on         = out_on_r;
  assign out_new_state     = out_st_r;
  assign out_power         = out_power_r;

endmodule
